// ----- hdl/lge_pkg.sv -----
// lge_pkg: shared types and constants for the life generation engine.
// No dependencies; imported by every module of the block.
package lge_pkg;

	// Field and register widths fixed by the interface
	localparam int ROW_W      = 6;
	localparam int COL_W      = 7;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Opcodes
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ    = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

	// Configuration reset values
	localparam logic [ROW_W-1:0] ROWS_RESET = 6'd20;
	localparam logic [COL_W-1:0] COLS_RESET = 7'd60;

	// Neighbor count: keep state on two, birth on three
	localparam int              CNT_W       = 4;
	localparam logic [CNT_W-1:0] KEEP_COUNT  = 4'd2;
	localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;

	// Cell store port controls
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

// ----- hdl/lge_cell_mem.sv -----
// lge_cell_mem: row-wide cell store, one write and one read port, registered read.
// Per-row valid bits make never-written rows read as dead. Uses lge_pkg.
module lge_cell_mem import lge_pkg::*; #(
	parameter int ROWS = 32,
	parameter int COLS = 64,
	localparam int AW  = $clog2(ROWS)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mem_ctl_t        ctl,
	input  logic [AW-1:0]   raddr,
	input  logic [AW-1:0]   waddr,
	input  logic [COLS-1:0] wdata,
	output logic [COLS-1:0] rdata
);

	logic [COLS-1:0] mem [ROWS];
	logic [ROWS-1:0] valid_q;
	logic [COLS-1:0] rd_q;
	logic            rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[waddr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_q : '0;

endmodule

// ----- hdl/lge_row_rule.sv -----
// lge_row_rule: B3/S23 next state for one full row from the rows above and below.
// Columns outside the mask keep their stored bit. Uses lge_pkg.
module lge_row_rule import lge_pkg::*; #(
	parameter int COLS = 64
) (
	input  logic [COLS-1:0] above,
	input  logic [COLS-1:0] mid,
	input  logic [COLS-1:0] below,
	input  logic [COLS-1:0] mid_raw,
	input  logic [COLS-1:0] col_mask,
	output logic [COLS-1:0] next_row
);

	logic [COLS+1:0] a_ext;
	logic [COLS+1:0] m_ext;
	logic [COLS+1:0] b_ext;

	// zero pad: edge columns see dead neighbors
	assign a_ext = {1'b0, above, 1'b0};
	assign m_ext = {1'b0, mid, 1'b0};
	assign b_ext = {1'b0, below, 1'b0};

	for (genvar c = 0; c < COLS; c++) begin : g_col
		logic [CNT_W-1:0] cnt;
		logic             live;

		assign cnt = CNT_W'(a_ext[c]) + CNT_W'(a_ext[c+1]) + CNT_W'(a_ext[c+2])
			+ CNT_W'(m_ext[c]) + CNT_W'(m_ext[c+2])
			+ CNT_W'(b_ext[c]) + CNT_W'(b_ext[c+1]) + CNT_W'(b_ext[c+2]);

		assign live = (cnt == KEEP_COUNT) ? mid[c] : (cnt == BIRTH_COUNT);
		assign next_row[c] = col_mask[c] ? live : mid_raw[c];
	end

endmodule

// ----- hdl/life_generation_engine.sv -----
// life_generation_engine: top level of the B3/S23 cell grid engine.
// Depends on lge_pkg, lge_cell_mem and lge_row_rule.
//
// Usage:
//   Command channel: an item (opcode, cell_row, cell_col, alive_in) is taken at a
//   clock edge with start high and busy low. Rows and columns are 1-based.
//   Result channel: done pulses for one cycle with cell_alive and out_of_area.
//   The receiver cannot stall; every item gives exactly one result.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 active_rows,
//   1 active_cols) and cfg_data; other indexes are dropped. cfg_ready is
//   always high; write only while the engine is idle.
// Sequencing:
//   Write, read or no-op: done is registered from ST_CELL; busy drops as
//   done rises, so the next item can be taken while done is high (one-row
//   read-modify-write). Advance: done ends the sweep of active_rows (rows
//   clipped to MAX_ROWS); the row sweep reads one row per cycle through the
//   single read port and writes the finished row above it back behind it.
// Reset: arst_n clears the grid (row valid bits, no sweep needed), state and
//   strobes, and loads active_rows = 20, active_cols = 60.
module life_generation_engine import lge_pkg::*; #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command
	input  logic                  start,
	output logic                  busy,
	input  logic [OP_W-1:0]       opcode,
	input  logic [ROW_W-1:0]      cell_row,
	input  logic [COL_W-1:0]      cell_col,
	input  logic                  alive_in,
	// result
	output logic                  done,
	output logic                  cell_alive,
	output logic                  out_of_area,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int RW  = $clog2(MAX_ROWS);
	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int CW  = $clog2(MAX_COLS);
	localparam int CCW = $clog2(MAX_COLS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_CELL, ST_ADV} state_t;

	// config
	logic [ROW_W-1:0]    active_rows_q;
	logic [COL_W-1:0]    active_cols_q;
	logic [RCW-1:0]      eff_rows;
	logic [CCW-1:0]      eff_cols;
	logic [MAX_COLS-1:0] col_mask;

	// command decode
	logic                accept;
	logic                in_area;
	logic                cell_op;
	logic [8:0]          row_base;
	logic [8:0]          col_base;

	// control
	state_t              state_q;
	logic                done_q;
	logic                cell_alive_q;
	logic                out_of_area_q;
	logic                issue_done_q;
	logic [RCW-1:0]      rd_cnt_q;
	logic                arr_v_s1;
	logic [RCW-1:0]      arr_idx_s1;

	// captured item
	logic [OP_W-1:0]     op_q;
	logic                oob_q;
	logic                alive_q;
	logic [RW-1:0]       row_q;
	logic [CW-1:0]       col_q;

	// sweep window: old rows r-1 and r (masked), old row r unmasked
	logic [MAX_COLS-1:0] prev_q;
	logic [MAX_COLS-1:0] cur_q;
	logic [MAX_COLS-1:0] cur_raw_q;

	// store access
	mem_ctl_t            mem_ctl;
	logic [RW-1:0]       raddr;
	logic [RW-1:0]       waddr;
	logic [MAX_COLS-1:0] wdata;
	logic [MAX_COLS-1:0] rdata;
	logic [MAX_COLS-1:0] next_row;
	logic [MAX_COLS-1:0] rule_row;
	logic [MAX_COLS-1:0] rmw_row;
	logic [RCW-1:0]      arr_prev_idx;
	logic                adv_issue;
	logic                arr_wr;
	logic                arr_last;
	logic                cell_wr;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_rows_q <= ROWS_RESET;
			active_cols_q <= COLS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROWS: begin
					active_rows_q <= cfg_data[ROW_W-1:0];
				end
				CFG_COLS: begin
					active_cols_q <= cfg_data[COL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// registers above the store size saturate
	assign eff_rows = (9'(active_rows_q) > 9'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(active_rows_q);
	assign eff_cols = (9'(active_cols_q) > 9'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(active_cols_q);

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			col_mask[c] = 9'(c) < 9'(eff_cols);
		end
	end

	// ---------------- command decode ----------------
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign cell_op  = (opcode == OP_WRITE) || (opcode == OP_READ);
	assign row_base = 9'(cell_row) - 9'd1;
	assign col_base = 9'(cell_col) - 9'd1;
	// row or column zero is outside the area
	assign in_area  = (cell_row != '0) && (9'(cell_row) <= 9'(eff_rows))
		&& (cell_col != '0) && (9'(cell_col) <= 9'(eff_cols));

	// ---------------- store access ----------------
	assign adv_issue    = (state_q == ST_ADV) && !issue_done_q && (rd_cnt_q < eff_rows);
	assign arr_prev_idx = arr_idx_s1 - RCW'(1);
	assign arr_wr       = (state_q == ST_ADV) && arr_v_s1 && (arr_idx_s1 != '0);
	assign arr_last     = (state_q == ST_ADV) && arr_v_s1 && (arr_idx_s1 == eff_rows);
	assign cell_wr      = (state_q == ST_CELL) && (op_q == OP_WRITE) && !oob_q;

	// row below the area (or past the store) is dead
	assign next_row = (arr_idx_s1 < eff_rows) ? (rdata & col_mask) : '0;

	always_comb begin
		rmw_row        = rdata;
		rmw_row[col_q] = alive_q;
	end

	assign mem_ctl.rd_en = (accept && in_area && cell_op) || adv_issue;
	assign mem_ctl.wr_en = cell_wr || arr_wr;
	assign raddr = (state_q == ST_IDLE) ? row_base[RW-1:0] : rd_cnt_q[RW-1:0];
	assign waddr = (state_q == ST_CELL) ? row_q : arr_prev_idx[RW-1:0];
	assign wdata = (state_q == ST_CELL) ? rmw_row : rule_row;

	lge_cell_mem #(
		.ROWS (MAX_ROWS),
		.COLS (MAX_COLS)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.raddr  (raddr),
		.waddr  (waddr),
		.wdata  (wdata),
		.rdata  (rdata)
	);

	lge_row_rule #(
		.COLS (MAX_COLS)
	) u_rule (
		.above    (prev_q),
		.mid      (cur_q),
		.below    (next_row),
		.mid_raw  (cur_raw_q),
		.col_mask (col_mask),
		.next_row (rule_row)
	);

	// ---------------- sequencer ----------------
	// Advance: rd_cnt_q issues rows 0..eff_rows (the last is a dummy slot for
	// the dead row below); arr_*_s1 tracks the row whose data lands this cycle.
	// Landing row k finishes row k-1, so writes trail reads by two rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			done_q        <= 1'b0;
			cell_alive_q  <= 1'b0;
			out_of_area_q <= 1'b0;
			issue_done_q  <= 1'b0;
			rd_cnt_q      <= '0;
			arr_v_s1      <= 1'b0;
			arr_idx_s1    <= '0;
		end else begin
			done_q        <= 1'b0;
			cell_alive_q  <= 1'b0;
			out_of_area_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == OP_ADVANCE) begin
							state_q      <= ST_ADV;
							rd_cnt_q     <= '0;
							issue_done_q <= 1'b0;
							arr_v_s1     <= 1'b0;
						end else begin
							state_q <= ST_CELL;
						end
					end
				end
				ST_CELL: begin
					state_q       <= ST_IDLE;
					done_q        <= 1'b1;
					out_of_area_q <= oob_q;
					cell_alive_q  <= !oob_q && (((op_q == OP_WRITE) && alive_q)
						|| ((op_q == OP_READ) && rdata[col_q]));
				end
				ST_ADV: begin
					arr_v_s1   <= !issue_done_q;
					arr_idx_s1 <= rd_cnt_q;
					if (!issue_done_q) begin
						if (rd_cnt_q == eff_rows) begin
							issue_done_q <= 1'b1;
						end else begin
							rd_cnt_q <= rd_cnt_q + RCW'(1);
						end
					end
					if (arr_last) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item capture and sweep window
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode;
			oob_q   <= !in_area && cell_op;
			alive_q <= alive_in;
			row_q   <= row_base[RW-1:0];
			col_q   <= col_base[CW-1:0];
		end
		if (accept && (opcode == OP_ADVANCE)) begin
			prev_q    <= '0;
			cur_q     <= '0;
			cur_raw_q <= '0;
		end else if ((state_q == ST_ADV) && arr_v_s1) begin
			prev_q    <= cur_q;
			cur_q     <= next_row;
			cur_raw_q <= rdata;
		end
	end

	assign done        = done_q;
	assign cell_alive  = cell_alive_q;
	assign out_of_area = out_of_area_q;

endmodule
